### rtl/core/assert_macros.svh
// Assertion macros shared by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge while reset is released.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a condition holds whenever a result request is presented.
`define ASSERT_WHEN_VALID(label, clk, rstn, vld, cond, msg) \
    `ASSERT_CLK(label, clk, rstn, (vld |-> (cond)), msg)

`endif

### rtl/core/adcspf_pkg.sv
// Package: constants and payload types of the ADC scan ping-pong framer.
package adcspf_pkg;

    localparam int FRAMES_PER_BANK_DEF = 256;
    localparam int NUM_CHANNELS_DEF    = 8;

    localparam int          GAIN_W     = 4;
    localparam int          CHAN_W     = 3;
    localparam logic [3:0]  GAIN_RESET = 4'd5;
    localparam logic [12:0] MID_SCALE  = 13'd2048;
    localparam logic [2:0]  CMD_BASE   = 3'b110;

    typedef struct packed {
        logic [7:0] resp_high;
        logic [7:0] resp_low;
    } in_t;

    typedef struct packed {
        logic               write_bank;
        logic [7:0]         frame_index;
        logic [2:0]         channel;
        logic signed [15:0] sample_value;
        logic               buffer_ready;
        logic [2:0]         next_cmd_first;
        logic [8:0]         next_cmd_second;
    } out_t;

endpackage

### rtl/core/adc_scan_pingpong_framer.sv
// A result is registered: it enters the result register, or the skid register while a result waits.
// Throughput: one request per cycle while the skid register is empty; a two-entry
// output stage (result register plus skid register) keeps taking requests while one result waits.
// Reset (aresetn low at a clock edge): channel, frame and bank counters clear,
// the gain returns to 5 and both output entries empty.
module adc_scan_pingpong_framer
    import adcspf_pkg::*;
#(
    parameter int FRAMES_PER_BANK = FRAMES_PER_BANK_DEF,
    parameter int NUM_CHANNELS    = NUM_CHANNELS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [GAIN_W-1:0] cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_t               s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_t              m_data
);

    // Frame counter wide enough to count up to the bank length minus one.
    localparam int FRAME_W = (FRAMES_PER_BANK > 2) ? $clog2(FRAMES_PER_BANK) : 1;

    // Configuration and scan state.
    logic [GAIN_W-1:0]  gain_reg;
    logic [CHAN_W-1:0]  chan_count_reg, chan_count_next;
    logic [FRAME_W-1:0] frame_count_reg, frame_count_next;
    logic               bank_reg, bank_next;

    // Output stage: result register and skid register.
    out_t out_reg, skid_reg;
    logic out_valid_reg, skid_valid_reg;

    logic               s_accept;
    logic               m_pop;
    logic               chan_last;
    logic               frame_last;
    logic               swap;
    logic [11:0]        raw;
    logic signed [12:0] centered;
    logic signed [17:0] scaled;
    out_t               result;

    // Accept a request whenever the skid register is free.
    assign s_ready  = !skid_valid_reg;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;
    assign m_pop    = out_valid_reg && m_ready;

    // Sample arithmetic: rebuild the 12-bit code, drop mid-scale, apply gain.
    always_comb begin
        raw      = {s_data.resp_high[3:0], s_data.resp_low};
        centered = $signed({1'b0, raw}) - $signed(MID_SCALE);
        scaled   = 18'(centered) * 18'($signed({1'b0, gain_reg}));
    end

    // Advance the channel; after the last channel advance the frame, and
    // after the last frame swap the bank and flag the buffer as ready.
    always_comb begin
        chan_last  = (chan_count_reg >= CHAN_W'(NUM_CHANNELS - 1));
        frame_last = (frame_count_reg >= FRAME_W'(FRAMES_PER_BANK - 1));
        swap       = chan_last && frame_last;

        chan_count_next  = chan_last ? '0 : chan_count_reg + 1'b1;
        frame_count_next = frame_count_reg;
        bank_next        = bank_reg;
        if (chan_last) begin
            frame_count_next = frame_last ? '0 : frame_count_reg + 1'b1;
        end
        if (swap) begin
            bank_next = !bank_reg;
        end
    end

    // Assemble the result; command words point at the channel after this one.
    always_comb begin
        result.write_bank      = bank_reg;
        result.frame_index     = 8'(frame_count_reg);
        result.channel         = chan_count_reg;
        result.sample_value    = scaled[15:0];
        result.buffer_ready    = swap;
        result.next_cmd_first  = CMD_BASE | {2'b00, chan_count_next[2]};
        result.next_cmd_second = {chan_count_next, 6'b000000};
    end

    // Hold scan state and gain; advance on each accepted request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg        <= GAIN_RESET;
            chan_count_reg  <= '0;
            frame_count_reg <= '0;
            bank_reg        <= 1'b0;
        end else begin
            if (cfg_we) begin
                gain_reg <= cfg_wdata;
            end
            if (s_accept) begin
                chan_count_reg  <= chan_count_next;
                frame_count_reg <= frame_count_next;
                bank_reg        <= bank_next;
            end
        end
    end

    // Output stage control: a new result goes to the result register when it
    // is free or being taken, otherwise to the skid register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (s_accept) begin
            if (out_valid_reg && !m_ready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (m_pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_pop) begin
                out_reg <= skid_reg;
            end
        end else if (s_accept) begin
            if (out_valid_reg && !m_ready) begin
                skid_reg <= result;
            end else begin
                out_reg <= result;
            end
        end
    end

endmodule

### rtl/core/adcspf_checker.sv
// Port checker for the ADC scan ping-pong framer, with its bind.
`include "assert_macros.svh"

module adcspf_checker
    import adcspf_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    `ASSERT_CLK(a_m_valid_hold, aclk, aresetn, (m_valid && !m_ready |=> m_valid), "result request dropped")
    `ASSERT_CLK(a_m_data_hold, aclk, aresetn, (m_valid && !m_ready |=> $stable(m_data)), "result changed while stalled")
    `ASSERT_WHEN_VALID(a_ready_last_chan, aclk, aresetn, (m_valid && m_data.buffer_ready), (m_data.channel == 3'(NUM_CHANNELS - 1)), "buffer ready off last channel")
    `ASSERT_WHEN_VALID(a_cmd_first, aclk, aresetn, m_valid, (m_data.next_cmd_first[2:1] == 2'b11), "bad first command byte")
    `ASSERT_WHEN_VALID(a_chan_range, aclk, aresetn, m_valid, (m_data.channel <= 3'(NUM_CHANNELS - 1)), "channel out of range")

endmodule

bind adc_scan_pingpong_framer adcspf_checker #(
    .NUM_CHANNELS(NUM_CHANNELS)
) u_adcspf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### tb/adc_scan_pingpong_framer_test.sv
// Self-checking testbench for the ADC scan ping-pong framer.
`timescale 1ns / 1ps

module adc_scan_pingpong_framer_test;
    import adcspf_pkg::*;

    localparam int HOLD_CYCLES  = 80;   // length of the long result back-pressure
    localparam int PHASE_ITEMS  = 76;   // random requests per gain setting
    localparam int NUM_PHASES   = 7;
    localparam int IDLE_PERCENT = 15;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [3:0]  cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_t         s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_t        m_data;

    // Requests still to be offered, and results predicted but not yet seen.
    in_t         queued_samples[$];
    out_t        expected_frames[$];

    // Predictor copy of the block's counters and gain register.
    logic [2:0]  chan_now     = '0;
    int          frame_now    = 0;
    logic        bank_now     = 1'b0;
    logic [3:0]  gain_setting = GAIN_RESET;

    int          mismatches     = 0;
    logic        calm           = 1'b0;  // suppress random idling on both sides
    logic        long_hold_req  = 1'b0;  // ask the result side for a long stall
    logic        long_hold_done = 1'b0;  // long stall already given
    int          hold_left      = 0;

    always #10 aclk = ~aclk;

    adc_scan_pingpong_framer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Work out the result for one accepted request and advance the scan
    // counters: channel first, then frame, then bank.
    function automatic out_t frame_sample(in_t req);
        out_t       res;
        logic [11:0] raw;
        int         scaled;
        logic [2:0] next_chan;
        raw    = {req.resp_high[3:0], req.resp_low};
        scaled = (int'(raw) - int'(MID_SCALE)) * int'(gain_setting);
        res.write_bank   = bank_now;
        res.frame_index  = frame_now[7:0];
        res.channel      = chan_now;
        res.sample_value = scaled[15:0];
        res.buffer_ready = 1'b0;
        if (chan_now >= 3'(NUM_CHANNELS_DEF - 1)) begin
            // last channel of the scan: wrap and move on to the next frame
            next_chan = '0;
            frame_now = frame_now + 1;
            if (frame_now >= FRAMES_PER_BANK_DEF) begin
                // bank full: swap banks and flag the completed one
                frame_now        = 0;
                bank_now         = ~bank_now;
                res.buffer_ready = 1'b1;
            end
        end else begin
            next_chan = chan_now + 3'd1;
        end
        chan_now            = next_chan;
        res.next_cmd_first  = CMD_BASE | {2'b00, next_chan[2]};
        res.next_cmd_second = {next_chan, 6'b000000};
        return res;
    endfunction

    function automatic in_t random_sample();
        in_t req;
        int  pick;
        pick          = $urandom_range(99);
        req.resp_high = 8'($urandom_range(255));
        req.resp_low  = 8'($urandom_range(255));
        // Bias a few requests towards full scale, zero scale and mid-scale,
        // keeping the ignored upper nibble random.
        if (pick < 4) begin
            req.resp_high[3:0] = 4'h0;
            req.resp_low       = 8'h00;
        end else if (pick < 8) begin
            req.resp_high[3:0] = 4'hF;
            req.resp_low       = 8'hFF;
        end else if (pick < 11) begin
            req.resp_high[3:0] = 4'h8;
            req.resp_low       = 8'h00;
        end
        return req;
    endfunction

    task automatic queue_sample(input logic [7:0] hi, input logic [7:0] lo);
        in_t req;
        req.resp_high = hi;
        req.resp_low  = lo;
        queued_samples.push_back(req);
    endtask

    // Hold until every request has gone in and every result has come out,
    // then let the output stage settle.
    task automatic wait_drained();
        while (queued_samples.size() != 0 || s_valid || expected_frames.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // Write the gain register; only ever called with the block idle.
    task automatic write_gain(input logic [3:0] gain);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= gain;
        @(posedge aclk);
        cfg_we       <= 1'b0;
        gain_setting = gain;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Request driver: offer the next queued sample whenever the channel is
    // free, idle now and then, and predict each request as it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_frames.push_back(frame_sample(s_data));
            if (!s_valid || s_ready) begin
                if (queued_samples.size() != 0 &&
                    (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
                    s_valid <= 1'b1;
                    s_data  <= queued_samples.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare every accepted result with the oldest
    // prediction, and drive ready with random stalls plus the long hold-off.
    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_frames.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with nothing expected, actual %h", $time, m_data);
                end else begin
                    want = expected_frames.pop_front();
                    check_field("write_bank", want.write_bank, m_data.write_bank);
                    check_field("frame_index", want.frame_index, m_data.frame_index);
                    check_field("channel", want.channel, m_data.channel);
                    check_field("sample_value", int'(want.sample_value),
                                int'(m_data.sample_value));
                    check_field("buffer_ready", want.buffer_ready, m_data.buffer_ready);
                    check_field("next_cmd_first", want.next_cmd_first,
                                m_data.next_cmd_first);
                    check_field("next_cmd_second", want.next_cmd_second,
                                m_data.next_cmd_second);
                end
            end
            if (long_hold_req && !long_hold_done) begin
                // drop ready for a long stretch so the block fills and stalls
                long_hold_done <= 1'b1;
                hold_left      <= HOLD_CYCLES;
                m_ready        <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // Watchdog: end the run if the traffic never drains.
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Stimulus sequence: reset, directed corners at three gains, then random
    // phases at a spread of gains.
    initial begin
        logic [3:0] gain;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset gain of 5: scale extremes, mid-scale, ignored upper nibble.
        // Nine requests also walk all channels and wrap into the next frame.
        queue_sample(8'hF0, 8'h00);
        queue_sample(8'h0F, 8'hFF);
        queue_sample(8'h08, 8'h00);
        queue_sample(8'h07, 8'hFF);
        queue_sample(8'hF8, 8'h00);
        queue_sample(8'hA5, 8'h5A);
        queue_sample(8'h5A, 8'hA5);
        queue_sample(8'h00, 8'h01);
        queue_sample(8'hFF, 8'hFE);
        wait_drained();

        // Largest gain: the most negative and most positive results.
        write_gain(4'd15);
        queue_sample(8'h00, 8'h00);
        queue_sample(8'h0F, 8'hFF);
        queue_sample(8'hF8, 8'h00);
        queue_sample(8'h07, 8'hFF);
        queue_sample(8'h18, 8'h01);
        wait_drained();

        // Zero gain: everything scales to nothing.
        write_gain(4'd0);
        queue_sample(8'h0F, 8'hFF);
        queue_sample(8'h00, 8'h00);
        queue_sample(8'h55, 8'hAA);
        wait_drained();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       gain = 4'd1;
                1:       gain = 4'd15;
                3:       gain = 4'd0;
                5:       gain = 4'd7;
                default: gain = 4'($urandom_range(15));
            endcase
            write_gain(gain);
            for (int n = 0; n < PHASE_ITEMS; n++)
                queued_samples.push_back(random_sample());
            // One phase with a long result stall while requests keep coming,
            // and one with no idling on either side.
            if (phase == 1)
                long_hold_req <= 1'b1;
            if (phase == 3)
                calm <= 1'b1;
            wait_drained();
            calm <= 1'b0;
        end

        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### adc_scan_pingpong_framer.f
+incdir+rtl/core
rtl/core/adcspf_pkg.sv
rtl/core/adc_scan_pingpong_framer.sv
rtl/core/adcspf_checker.sv
tb/adc_scan_pingpong_framer_test.sv
